// ===== design/ftld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftld_pkg
// Shared types, field type codes and character tables for the FRU
// type/length field decoder.
// ----------------------------------------------------------------------------
package ftld_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CountWidth = 3;
    localparam int unsigned IndexWidth = 2;

    localparam logic [1:0] TYPE_BINARY = 2'd0;
    localparam logic [1:0] TYPE_BCD    = 2'd1;
    localparam logic [1:0] TYPE_ASCII6 = 2'd2;
    localparam logic [1:0] TYPE_ASCII8 = 2'd3;

    localparam logic [7:0] SIX_BIT_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0] char_code;
        logic [1:0] field_type;
        logic       empty_field;
        logic       field_end;
    } result_t;

    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic [CountWidth-1:0]    count;
    } batch_t;

    // Lowercase hex digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        unique case (nib)
            4'h0: ch = "0";
            4'h1: ch = "1";
            4'h2: ch = "2";
            4'h3: ch = "3";
            4'h4: ch = "4";
            4'h5: ch = "5";
            4'h6: ch = "6";
            4'h7: ch = "7";
            4'h8: ch = "8";
            4'h9: ch = "9";
            4'ha: ch = "a";
            4'hb: ch = "b";
            4'hc: ch = "c";
            4'hd: ch = "d";
            4'he: ch = "e";
            default: ch = "f";
        endcase
        return ch;
    endfunction

    // BCD-plus character for one nibble.
    function automatic logic [7:0] bcd_char(input logic [3:0] nib);
        logic [7:0] ch;
        unique case (nib)
            4'h0: ch = "0";
            4'h1: ch = "1";
            4'h2: ch = "2";
            4'h3: ch = "3";
            4'h4: ch = "4";
            4'h5: ch = "5";
            4'h6: ch = "6";
            4'h7: ch = "7";
            4'h8: ch = "8";
            4'h9: ch = "9";
            4'ha: ch = " ";
            4'hb: ch = "-";
            4'hc: ch = ".";
            4'hd: ch = ":";
            4'he: ch = ",";
            default: ch = "_";
        endcase
        return ch;
    endfunction

endpackage

// ===== design/ftld_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftld_decode
// Field state registers and the single-pass decode of one FRU byte into a
// batch of up to four characters.
// ----------------------------------------------------------------------------
module ftld_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    output ftld_pkg::batch_t batch
);
    import ftld_pkg::*;

    logic [5:0]  bytes_left_reg, bytes_left_next;
    logic [1:0]  current_type_reg, current_type_next;
    logic [15:0] group_bytes_reg, group_bytes_next;
    logic [1:0]  group_index_reg, group_index_next;

    logic [5:0]  left_dec;
    logic        fend;
    logic [23:0] group_word;

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        current_type_next = current_type_reg;
        group_bytes_next  = group_bytes_reg;
        group_index_next  = group_index_reg;
        batch             = '0;
        left_dec          = bytes_left_reg - 6'd1;
        fend              = (left_dec == 6'd0);
        group_word        = {8'd0, group_bytes_reg};

        case (group_index_reg)
            2'd0:    group_word = {16'd0, data_byte};
            2'd1:    group_word = {8'd0, data_byte, group_bytes_reg[7:0]};
            default: group_word = {data_byte, group_bytes_reg};
        endcase

        if (bytes_left_reg == 6'd0) begin
            // Header byte: type in the top two bits, length below.
            if (data_byte[5:0] == 6'd0) begin
                batch.res[0].char_code   = 8'd0;
                batch.res[0].field_type  = data_byte[7:6];
                batch.res[0].empty_field = 1'b1;
                batch.res[0].field_end   = 1'b1;
                batch.count              = CountWidth'(1);
            end else begin
                bytes_left_next   = data_byte[5:0];
                current_type_next = data_byte[7:6];
                group_bytes_next  = 16'd0;
                group_index_next  = 2'd0;
            end
        end else begin
            bytes_left_next = left_dec;
            unique case (current_type_reg)
                TYPE_BINARY:
                begin
                    batch.res[0].char_code  = hex_char(data_byte[7:4]);
                    batch.res[0].field_type = TYPE_BINARY;
                    batch.res[1].char_code  = hex_char(data_byte[3:0]);
                    batch.res[1].field_type = TYPE_BINARY;
                    batch.res[1].field_end  = fend;
                    batch.count             = CountWidth'(2);
                end
                TYPE_BCD:
                begin
                    batch.res[0].char_code  = bcd_char(data_byte[3:0]);
                    batch.res[0].field_type = TYPE_BCD;
                    batch.res[0].field_end  = fend;
                    batch.count             = CountWidth'(1);
                end
                TYPE_ASCII8:
                begin
                    batch.res[0].char_code  = data_byte;
                    batch.res[0].field_type = TYPE_ASCII8;
                    batch.res[0].field_end  = fend;
                    batch.count             = CountWidth'(1);
                end
                default:
                begin
                    // Six-bit ASCII: a full group, or the field's last byte,
                    // flushes four characters; missing bytes read as zero.
                    if (group_index_reg >= 2'd2 || fend) begin
                        for (int k = 0; k < MaxResults; k++) begin
                            batch.res[k].char_code  =
                                {2'b00, group_word[6*k +: 6]} + SIX_BIT_OFFSET;
                            batch.res[k].field_type = TYPE_ASCII6;
                        end
                        batch.res[MaxResults-1].field_end = fend;
                        batch.count      = CountWidth'(MaxResults);
                        group_bytes_next = 16'd0;
                        group_index_next = 2'd0;
                    end else begin
                        group_bytes_next = group_word[15:0];
                        group_index_next = group_index_reg + 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bytes_left_reg   <= 6'd0;
            current_type_reg <= 2'd0;
            group_bytes_reg  <= 16'd0;
            group_index_reg  <= 2'd0;
        end else if (accept) begin
            bytes_left_reg   <= bytes_left_next;
            current_type_reg <= current_type_next;
            group_bytes_reg  <= group_bytes_next;
            group_index_reg  <= group_index_next;
        end
    end

endmodule

// ===== design/ftld_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftld_emit
// Result register that holds one decoded batch and hands its characters
// out one per cycle while char_ready is high.
// ----------------------------------------------------------------------------
module ftld_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ftld_pkg::batch_t batch,
    output logic             can_load,
    output logic             char_valid,
    input  logic             char_ready,
    output logic [7:0]       char_code,
    output logic [1:0]       field_type,
    output logic             empty_field,
    output logic             last_of_run,
    output logic             field_end
);
    import ftld_pkg::*;

    batch_t                batch_reg;
    logic [IndexWidth-1:0] idx_reg, idx_next;
    logic                  busy_reg, busy_next;
    logic                  last;
    result_t               cur;

    assign cur  = batch_reg.res[idx_reg];
    assign last = ({1'b0, idx_reg} + CountWidth'(1)) == batch_reg.count;

    assign char_valid  = busy_reg;
    assign char_code   = cur.char_code;
    assign field_type  = cur.field_type;
    assign empty_field = cur.empty_field;
    assign field_end   = cur.field_end;
    assign last_of_run = last;

    // A new batch may enter when nothing is held or the final character
    // is leaving in this cycle.
    assign can_load = !busy_reg || (char_ready && last);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = (batch.count != CountWidth'(0));
            idx_next  = '0;
        end else if (busy_reg && char_ready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IndexWidth'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            batch_reg <= batch;
        end
    end

endmodule

// ===== design/fru_type_length_field_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fru_type_length_field_decoder
// Decodes IPMI FRU type/length encoded fields into a stream of characters.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a FRU area enter on the byte channel (data_byte, byte_valid,
// byte_ready). With no field open a byte is a type/length header; otherwise
// it is field data. Characters leave on the char channel (char_code,
// field_type, empty_field, last_of_run, field_end, char_valid, char_ready).
// Each input item is decoded in one pass at the cycle it is accepted, and
// its characters are presented from the result register starting on the
// next cycle, one per cycle while char_ready is high.
// Throughput is bound by the one-character-per-cycle result port: an 8-bit
// ASCII or BCD plus byte or an empty-field header gives one character, a
// binary byte two, a byte closing a six-bit group four. Bytes that give no
// result are taken every cycle while the result register can load.
// A new item is accepted in the same cycle that the last character of the
// previous one is taken, so the block runs back to back.
// Reset clears the open field, so the first byte after reset is a header,
// and empties the result register. When the receiver stalls, the current
// character holds and byte_ready stays low until the batch's last character leaves.
// ----------------------------------------------------------------------------
module fru_type_length_field_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    output logic       byte_ready,
    output logic [7:0] char_code,
    output logic [1:0] field_type,
    output logic       empty_field,
    output logic       last_of_run,
    output logic       field_end,
    output logic       char_valid,
    input  logic       char_ready
);
    import ftld_pkg::*;

    batch_t batch;
    logic   can_load;
    logic   accept;

    // The byte is taken whenever the result register can hold its batch.
    assign byte_ready = can_load;
    assign accept     = byte_valid && can_load;

    ftld_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .batch     (batch)
    );

    ftld_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .batch       (batch),
        .can_load    (can_load),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .field_type  (field_type),
        .empty_field (empty_field),
        .last_of_run (last_of_run),
        .field_end   (field_end)
    );

endmodule
